>>> rtl/frlm_pkg.sv
`default_nettype none
package frlm_pkg;

	localparam int MAX_ENTRIES_DEF = 256;
	localparam int LINE_BITS_DEF   = 20;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_INVALID = 2'd1;
	localparam status_t ST_FULL    = 2'd2;

	localparam logic OP_SET   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

endpackage
`default_nettype wire

>>> rtl/fold_region_line_mapper_core.sv
`default_nettype none
// Fold table and line mapper. A set word (op 0) updates the entry whose start line matches or
// appends a new entry, or reports ST_FULL if the table is full; a query word (op 1) reports
// whether the line is hidden inside a collapsed fold, or its visual index otherwise. Every
// query and every set with a valid interval walks the stored entries one per cycle through the
// single read port of the entry memory, stopping early when a set finds its start line or a
// query finds its line hidden; a rejected interval (end not above start) skips the walk and
// reports ST_INVALID. One word is in work at a time; in_stall is high from acceptance until its
// result is handed to the output register, which holds it while out_stall is high, so the next
// word is taken in the cycle after that at the earliest. No clearing pass is needed after reset.
module fold_region_line_mapper_core #(
	parameter int MAX_ENTRIES = frlm_pkg::MAX_ENTRIES_DEF,
	parameter int LINE_BITS   = frlm_pkg::LINE_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire                          op,
	input  wire  [LINE_BITS-1:0]         fold_start,
	input  wire  [LINE_BITS-1:0]         fold_end,
	input  wire                          collapse,
	input  wire  [LINE_BITS-1:0]         query_line,
	output logic                         out_valid,
	input  wire                          out_stall,
	output frlm_pkg::status_t            status,
	output logic                         fold_changed,
	output logic                         hidden,
	output logic [LINE_BITS-1:0]         view_line
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int DW = 3 * LINE_BITS + 1;
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [DW-1:0] mem [MAX_ENTRIES];

	logic [1:0]           state_q;
	logic [CW-1:0]        idx_q;
	logic [CW-1:0]        cnt_q;
	logic                 rd_vld_s1;
	logic [AW-1:0]        rd_idx_s1;
	logic [DW-1:0]        rd_data_s1;

	logic                 op_q;
	logic [LINE_BITS-1:0] s_q;
	logic [LINE_BITS-1:0] e_q;
	logic                 c_q;
	logic [LINE_BITS-1:0] len_q;
	logic [LINE_BITS-1:0] q_q;
	logic [LINE_BITS-1:0] vis_q;

	frlm_pkg::status_t    res_status_q;
	logic                 res_chg_q;
	logic                 res_hid_q;
	logic [LINE_BITS-1:0] res_vis_q;

	logic                 in_fire;
	logic                 bad_iv;
	logic                 issue;
	logic                 scan_end;
	logic                 match;
	logic                 hide;
	logic                 sub_en;
	logic                 out_free;
	logic                 full;
	logic                 we;
	logic [AW-1:0]        wa;
	logic [LINE_BITS-1:0] ent_s;
	logic [LINE_BITS-1:0] ent_e;
	logic [LINE_BITS-1:0] ent_len;
	logic                 ent_c;
	logic [LINE_BITS:0]   diff;

	assign in_stall = (state_q != S_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign bad_iv   = (op == frlm_pkg::OP_SET) && (fold_end <= fold_start);

	assign ent_s   = rd_data_s1[LINE_BITS-1:0];
	assign ent_e   = rd_data_s1[2*LINE_BITS-1:LINE_BITS];
	assign ent_len = rd_data_s1[3*LINE_BITS-1:2*LINE_BITS];
	assign ent_c   = rd_data_s1[DW-1];

	assign issue    = (state_q == S_SCAN) && (idx_q < cnt_q);
	assign scan_end = (state_q == S_SCAN) && !rd_vld_s1 && !issue;
	assign match    = (state_q == S_SCAN) && rd_vld_s1 && (op_q == frlm_pkg::OP_SET)
		&& (ent_s == s_q);
	assign hide     = (state_q == S_SCAN) && rd_vld_s1 && (op_q == frlm_pkg::OP_QUERY)
		&& ent_c && (q_q > ent_s) && (q_q <= ent_e);
	assign sub_en   = (state_q == S_SCAN) && rd_vld_s1 && (op_q == frlm_pkg::OP_QUERY)
		&& ent_c && !hide && (ent_e < q_q);
	assign diff     = {1'b0, vis_q} - {1'b0, ent_len};
	assign full     = (cnt_q == CNT_MAX);
	assign out_free = !out_valid || !out_stall;

	assign we = match || (scan_end && (op_q == frlm_pkg::OP_SET) && !full);
	assign wa = match ? rd_idx_s1 : cnt_q[AW-1:0];

	// entry memory: {collapsed, length, end, start}
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= {c_q, len_q, e_q, s_q};
		end
		if (issue) begin
			rd_data_s1 <= mem[idx_q[AW-1:0]];
			rd_idx_s1  <= idx_q[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			idx_q     <= '0;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (in_fire) begin
						idx_q   <= '0;
						state_q <= bad_iv ? S_DONE : S_SCAN;
					end
				end
				S_SCAN: begin
					rd_vld_s1 <= issue;
					if (issue) begin
						idx_q <= idx_q + 1'b1;
					end
					if (match || hide) begin
						rd_vld_s1 <= 1'b0;
						state_q   <= S_DONE;
					end else if (scan_end) begin
						if ((op_q == frlm_pkg::OP_SET) && !full) begin
							cnt_q <= cnt_q + 1'b1;
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					rd_vld_s1 <= 1'b0;
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q   <= S_IDLE;
					rd_vld_s1 <= 1'b0;
				end
			endcase
			if ((state_q == S_DONE) && out_free) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q  <= op;
			s_q   <= fold_start;
			e_q   <= fold_end;
			c_q   <= collapse;
			len_q <= fold_end - fold_start;
			q_q   <= query_line;
			vis_q <= query_line;
			if (bad_iv) begin
				res_status_q <= frlm_pkg::ST_INVALID;
				res_chg_q    <= 1'b0;
				res_hid_q    <= 1'b0;
				res_vis_q    <= '0;
			end
		end
		if (sub_en) begin
			vis_q <= diff[LINE_BITS] ? '0 : diff[LINE_BITS-1:0];
		end
		if (match) begin
			res_status_q <= frlm_pkg::ST_OK;
			res_chg_q    <= 1'b1;
			res_hid_q    <= 1'b0;
			res_vis_q    <= '0;
		end else if (hide) begin
			res_status_q <= frlm_pkg::ST_OK;
			res_chg_q    <= 1'b0;
			res_hid_q    <= 1'b1;
			res_vis_q    <= '0;
		end else if (scan_end) begin
			res_hid_q <= 1'b0;
			if (op_q == frlm_pkg::OP_SET) begin
				res_status_q <= full ? frlm_pkg::ST_FULL : frlm_pkg::ST_OK;
				res_chg_q    <= !full;
				res_vis_q    <= '0;
			end else begin
				res_status_q <= frlm_pkg::ST_OK;
				res_chg_q    <= 1'b0;
				res_vis_q    <= vis_q;
			end
		end
		if ((state_q == S_DONE) && out_free) begin
			status       <= res_status_q;
			fold_changed <= res_chg_q;
			hidden       <= res_hid_q;
			view_line    <= res_vis_q;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("entry count above table size");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + 1'b1))
		else $error("entry count moved by more than one");

	a_chg_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(fold_changed && (status != frlm_pkg::ST_OK)))
		else $error("fold change reported with error status");

	a_hid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hidden) |-> ((view_line == '0) && !fold_changed))
		else $error("hidden line with nonzero index or change flag");

	a_write_scan: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> ((state_q == S_SCAN) && (op_q == frlm_pkg::OP_SET)))
		else $error("table written outside a set scan");

endmodule
`default_nettype wire
